>>> design/assert_macros.svh
// Assertion macros shared by the fingerprint unit's queue and back part.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

>>> design/rrf_pkg.sv
// Types, constants and table builders for the rolling fingerprint unit.
package rrf_pkg;

  localparam int unsigned PRINT_W          = 63;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned WINDOW_BYTES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  localparam logic [63:0] POLY = 64'hbfe6b8a5bf378d83;
  localparam logic [63:0] TOP  = 64'h8000000000000000;

  typedef logic [255:0][PRINT_W-1:0] tab_t;

  // A request between the front and back parts.
  typedef struct packed {
    logic [PRINT_W-1:0] contrib;
    logic [BYTE_W-1:0]  entering;
    logic               restart;
  } item_t;

  // Reduces the 128-bit carry-less value hi:lo modulo the polynomial.
  function automatic logic [63:0] gf_mod(input logic [63:0] hi_in, input logic [63:0] lo_in);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = hi_in;
    lo = lo_in;
    if (hi != 64'd0) begin
      if (hi[63]) hi ^= POLY;
      for (int i = 62; i >= 0; i--) begin
        if (hi[6'(i)]) begin
          hi ^= POLY >> (63 - i);
          lo ^= POLY << (i + 1);
        end
      end
    end
    if (lo[63]) lo ^= POLY;
    return lo;
  endfunction

  function automatic logic [63:0] gf_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = 64'd0;
    lo = a[0] ? b : 64'd0;
    for (int i = 1; i < 64; i++) begin
      if (a[6'(i)]) begin
        hi ^= b >> (64 - i);
        lo ^= b << i;
      end
    end
    return gf_mod(hi, lo);
  endfunction

  function automatic tab_t build_red();
    tab_t        t;
    logic [63:0] x63;
    logic [63:0] prod;
    x63 = gf_mod(64'd0, TOP);
    for (int j = 0; j < 256; j++) begin
      prod = gf_mul(64'(j), x63);
      t[8'(j)] = prod[PRINT_W-1:0];
    end
    return t;
  endfunction

  localparam tab_t RED_TAB = build_red();

  // Multiplies a residue by x^8, appends a byte and folds the overflow back in.
  function automatic logic [PRINT_W-1:0] shift_in(input logic [PRINT_W-1:0] r,
                                                  input logic [BYTE_W-1:0] b);
    return {r[PRINT_W-BYTE_W-1:0], b} ^ RED_TAB[r[PRINT_W-1:PRINT_W-BYTE_W]];
  endfunction

  // Contribution of each leaving byte: b * x^(8*(window-1)) mod P.
  function automatic tab_t build_out(input int window);
    tab_t               t;
    logic [PRINT_W-1:0] span;
    logic [63:0]        prod;
    span = PRINT_W'(1);
    for (int j = 1; j < window; j++) begin
      span = shift_in(span, 8'd0);
    end
    for (int j = 0; j < 256; j++) begin
      prod = gf_mul(64'(j), {1'b0, span});
      t[8'(j)] = prod[PRINT_W-1:0];
    end
    return t;
  endfunction

endpackage

>>> design/rrf_fifo.sv
// Small first-in first-out queue built from registers.
`include "assert_macros.svh"

module rrf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `ASSERT_ALWAYS(fifo_reset_empty_a, !rst_ni |=> empty_o)
  `ASSERT_CLK(fifo_cnt_range_a, cnt_q <= CntW'(Depth))
  `ASSERT_CLK(fifo_push_lands_a, do_push && !do_pop |=> !empty_o)

endmodule

>>> design/rrf_front.sv
// Front part: takes bytes in, looks up the leaving byte's share and queues the request.
module rrf_front #(
  parameter int unsigned WINDOW_BYTES = rrf_pkg::WINDOW_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = rrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [rrf_pkg::BYTE_W-1:0] leaving_byte_i,
  input  logic [rrf_pkg::BYTE_W-1:0] entering_byte_i,
  input  logic                       restart_i,
  input  logic                       mid_pop_i,
  output rrf_pkg::item_t             mid_o,
  output logic                       mid_empty_o
);

  import rrf_pkg::*;

  localparam tab_t OutTab = build_out(int'(WINDOW_BYTES));

  item_t in_item;

  always_comb begin
    in_item.contrib  = OutTab[leaving_byte_i];
    in_item.entering = entering_byte_i;
    in_item.restart  = restart_i;
  end

  rrf_fifo #(
    .Width ($bits(item_t)),
    .Depth (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (in_item),
    .full_o  (full_o),
    .pop_i   (mid_pop_i),
    .data_o  (mid_o),
    .empty_o (mid_empty_o)
  );

endmodule

>>> design/rrf_back.sv
// Back part: holds the running fingerprint, folds in each request and queues the result.
`include "assert_macros.svh"

module rrf_back #(
  parameter int unsigned QUEUE_DEPTH = rrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrf_pkg::item_t              mid_i,
  input  logic                        mid_empty_i,
  output logic                        mid_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [rrf_pkg::PRINT_W-1:0] fingerprint_o
);

  import rrf_pkg::*;

  logic [PRINT_W-1:0] state_q, state_d;
  logic [PRINT_W-1:0] prev, mixed, res;
  logic               out_full, xfer;

  assign xfer      = ~mid_empty_i & ~out_full;
  assign mid_pop_o = xfer;

  // A restart drops the stored residue, but the leaving byte is still removed.
  always_comb begin
    prev    = mid_i.restart ? '0 : state_q;
    mixed   = prev ^ mid_i.contrib;
    res     = shift_in(mixed, mid_i.entering);
    state_d = xfer ? res : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  rrf_fifo #(
    .Width (PRINT_W),
    .Depth (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (xfer),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (fingerprint_o),
    .empty_o (empty_o)
  );

  `ASSERT_CLK(back_hold_a, !xfer |=> $stable(state_q))
  `ASSERT_CLK(back_zero_restart_a,
    xfer && mid_i.restart && mid_i.contrib == '0 && mid_i.entering == '0 |=> state_q == '0)

endmodule

>>> design/rabin_rolling_fingerprint_unit.sv
// Rolling Rabin fingerprint unit: top level joining the front and back parts.
//
// Usage: each input request carries the byte leaving the window, the byte
// entering it and a restart flag. It is taken at a rising edge with push high
// and full low. Each request gives exactly one 63-bit fingerprint, the running
// residue modulo the fixed degree-63 polynomial after that byte.
// Results wait in a queue: while empty is low the oldest one is on
// fingerprint_o, and it is taken at a rising edge with pop high.
// A request goes first into the request queue; the back part moves it into the
// result queue when that has room, and then empty falls and it can be popped.
// Throughput: one request per cycle while full is low; the loop around the
// running residue is a table lookup and two XOR levels, closed in the back part.
// When the receiver stalls, the result queue fills, then the request queue,
// and full rises; nothing is dropped. Reset clears both queues and sets the
// running fingerprint to zero. No clearing pass is needed.
module rabin_rolling_fingerprint_unit #(
  parameter int unsigned WINDOW_BYTES = rrf_pkg::WINDOW_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = rrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [rrf_pkg::BYTE_W-1:0]  leaving_byte_i,
  input  logic [rrf_pkg::BYTE_W-1:0]  entering_byte_i,
  input  logic                        restart_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [rrf_pkg::PRINT_W-1:0] fingerprint_o
);

  import rrf_pkg::*;

  item_t mid;
  logic  mid_empty, mid_pop;

  rrf_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .leaving_byte_i  (leaving_byte_i),
    .entering_byte_i (entering_byte_i),
    .restart_i       (restart_i),
    .mid_pop_i       (mid_pop),
    .mid_o           (mid),
    .mid_empty_o     (mid_empty)
  );

  rrf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mid_i         (mid),
    .mid_empty_i   (mid_empty),
    .mid_pop_o     (mid_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .fingerprint_o (fingerprint_o)
  );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the rolling Rabin fingerprint unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WINDOW = rrf_pkg::WINDOW_BYTES_DEF;
  localparam int unsigned PW     = rrf_pkg::PRINT_W;
  localparam int unsigned BW     = rrf_pkg::BYTE_W;

  // Predicts each fingerprint and keeps the ones that are still owed.
  class fingerprint_board;
    logic [PW-1:0] leave_tab [256];
    logic [PW-1:0] running_print;
    logic [PW-1:0] owed_prints [$];
    int unsigned   checked;

    function new();
      logic [PW-1:0] span;
      logic [PW-1:0] term;
      logic [PW-1:0] acc;
      span = PW'(1);
      repeat (8 * (WINDOW - 1)) span = times_x(span);
      for (int j = 0; j < 256; j++) begin
        acc  = '0;
        term = span;
        for (int k = 0; k < 8; k++) begin
          if (j[5'(k)]) acc ^= term;
          term = times_x(term);
        end
        leave_tab[8'(j)] = acc;
      end
      running_print = '0;
      checked       = 0;
    endfunction

    // Multiplies a residue by x and reduces it modulo the polynomial.
    function logic [PW-1:0] times_x(logic [PW-1:0] v);
      logic [63:0] t;
      t = {v, 1'b0};
      if (t[63]) t ^= rrf_pkg::POLY;
      return t[PW-1:0];
    endfunction

    function void note_request(logic [BW-1:0] leaving, logic [BW-1:0] entering,
                               logic restart);
      logic [PW-1:0] r;
      r = restart ? '0 : running_print;
      r ^= leave_tab[leaving];
      repeat (BW) r = times_x(r);
      r ^= PW'(entering);
      running_print = r;
      owed_prints.push_back(r);
    endfunction

    function bit check_print(logic [PW-1:0] got, output string why);
      logic [PW-1:0] want;
      why = "";
      if (owed_prints.size() == 0) begin
        why = $sformatf("fingerprint %h arrived with no request waiting", got);
        return 1'b0;
      end
      want = owed_prints.pop_front();
      checked++;
      if (got !== want) begin
        why = $sformatf("result %0d: fingerprint %h, predicted %h", checked, got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned pending();
      return owed_prints.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          push;
  logic          full;
  logic [BW-1:0] leaving_byte_i;
  logic [BW-1:0] entering_byte_i;
  logic          restart_i;
  logic          empty;
  logic          pop;
  logic [PW-1:0] fingerprint_o;

  fingerprint_board board;
  int unsigned      errors;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_request;
  logic [BW-1:0]    window_bytes [$];
  int unsigned      stream_left;

  rabin_rolling_fingerprint_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .leaving_byte_i (leaving_byte_i),
    .entering_byte_i(entering_byte_i),
    .restart_i      (restart_i),
    .empty          (empty),
    .pop            (pop),
    .fingerprint_o  (fingerprint_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(string why);
    $display("MISMATCH at %0t: %s", $time, why);
    errors++;
  endtask

  task automatic send_request(logic [BW-1:0] leaving, logic [BW-1:0] entering,
                              logic restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push            = 1'b1;
    leaving_byte_i  = leaving;
    entering_byte_i = entering;
    restart_i       = restart;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_request(leaving, entering, restart);
  endtask

  // Mostly whole streams whose leaving byte is the one that entered a window
  // earlier, with unrelated requests mixed in to break them.
  task automatic send_random(int unsigned count);
    logic [BW-1:0] leaving;
    logic [BW-1:0] entering;
    logic          restart;
    repeat (count) begin
      if ($urandom_range(99) < 12) begin
        send_request(BW'($urandom_range(255)), BW'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else begin
        restart = 1'b0;
        if (stream_left == 0) begin
          stream_left = $urandom_range(700, 40);
          window_bytes.delete();
          restart = 1'b1;
        end
        leaving  = (window_bytes.size() == WINDOW) ? window_bytes.pop_front() : '0;
        entering = BW'($urandom_range(255));
        window_bytes.push_back(entering);
        stream_left--;
        send_request(leaving, entering, restart);
      end
    end
  endtask

  // Receiver: samples at the rising edge, decides pop at the falling edge.
  initial begin
    int unsigned hold_left;
    string       why;
    hold_left = 0;
    pop       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (!board.check_print(fingerprint_o, why)) report_mismatch(why);
      end
      @(negedge clk_i);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("rabin_rolling_fingerprint_unit test failed");
    $finish;
  end

  initial begin
    board           = new();
    errors          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    stream_left     = 0;
    push            = 1'b0;
    leaving_byte_i  = '0;
    entering_byte_i = '0;
    restart_i       = 1'b0;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, removal while the window is still filling, and restarts
    // with both a zero and a nonzero leaving byte.
    send_request(8'h00, 8'h00, 1'b0);
    send_request(8'h00, 8'hff, 1'b0);
    send_request(8'hff, 8'h00, 1'b0);
    send_request(8'hff, 8'hff, 1'b0);
    send_request(8'h00, 8'h00, 1'b1);
    send_request(8'h00, 8'ha5, 1'b1);
    send_request(8'hff, 8'hff, 1'b1);
    send_request(8'h80, 8'h01, 1'b0);
    send_request(8'h01, 8'h80, 1'b0);
    send_request(8'h55, 8'haa, 1'b0);
    send_request(8'haa, 8'h55, 1'b0);
    // Enough all-ones bytes to push the residue through its top bits.
    repeat (10) send_request(8'h00, 8'hff, 1'b0);

    send_random(350);
    send_idle_pct = 49;
    send_random(350);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    send_random(350);

    // The receiver stops for a long stretch while requests keep coming.
    recv_stall_pct = 0;
    hold_request   = 120;
    send_random(200);

    send_idle_pct  = 37;
    recv_stall_pct = 37;
    send_random(350);

    @(negedge clk_i);
    push = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("rabin_rolling_fingerprint_unit test passed");
    end else begin
      $display("rabin_rolling_fingerprint_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/rrf_pkg.sv
design/rrf_fifo.sv
design/rrf_front.sv
design/rrf_back.sv
design/rabin_rolling_fingerprint_unit.sv
tb/sv/tb_top.sv
